// File: rtl/rcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_pkg: shared types and constants of the RIFF chunk finder
// Word layouts of the byte and result channels, magic words, walk phases
// and status codes.
// ----------------------------------------------------------------------------
package rcf_pkg;

	localparam logic [31:0] MAGIC_RIFF  = 32'h4646_4952;
	localparam logic [31:0] MAGIC_WAVE  = 32'h4556_4157;
	localparam logic [31:0] MAGIC_AXML  = 32'h6c6d_7861;
	localparam logic [33:0] FIRST_CHUNK = 34'd12;
	localparam logic [34:0] HDR_LEN     = 35'd8;

	localparam logic [1:0] PH_FILE_HDR = 2'd0;
	localparam logic [1:0] PH_WALK     = 2'd1;
	localparam logic [1:0] PH_PAYLOAD  = 2'd2;

	localparam logic [1:0] ST_PAYLOAD   = 2'd0;
	localparam logic [1:0] ST_NOT_RIFF  = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic REG_TOTAL_SIZE = 1'b0;
	localparam logic REG_CHUNK_ID   = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} rcf_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} rcf_out_t;

endpackage

// File: rtl/rcf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_in_if: file byte channel
// Valid/ready channel that carries one file byte and its first-byte flag.
// ----------------------------------------------------------------------------
interface rcf_in_if
	import rcf_pkg::*;
();
	logic    valid;
	logic    ready;
	rcf_in_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/rcf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcf_out_if: result channel
// Valid/ready channel that carries one payload byte or status word.
// ----------------------------------------------------------------------------
interface rcf_out_if
	import rcf_pkg::*;
();
	logic     valid;
	logic     ready;
	rcf_out_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/riff_chunk_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riff_chunk_finder: RIFF WAVE chunk scanner
// Walks the chunk headers of a byte stream and returns the payload of the
// first chunk with the configured ID, or a not-RIFF / not-found status.
// ----------------------------------------------------------------------------
// Usage:
//   bytes   : one file byte per word; first_byte restarts the walk.
//   results : payload bytes of the matching chunk (last on the final one),
//             or a single status word with last set.
//   cfg     : write total_size (index 0) and chunk_id (index 1) while idle.
// Throughput is one byte per cycle while the receiver keeps up. A byte is
// captured in the input stage, evaluated against the walk state in the next
// cycle, and its result, if any, is registered in the output register when
// the input stage advances; the receiver takes it from there.
// The chunk end sum and the next-offset fit check against total_size set
// the cycle time.
// When the receiver stalls, the output register holds its word; the input
// stage fills and then ready drops until the output drains.
// Reset clears the walk to the file header, total_size to zero and
// chunk_id to "axml". Bytes after a decision give no result until a word
// with first_byte set arrives.
// ----------------------------------------------------------------------------
module riff_chunk_finder
	import rcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	rcf_in_if.sink      bytes,
	rcf_out_if.source   results
);

	logic [31:0] total_size_q;
	logic [31:0] chunk_id_q;

	logic        valid_s1;
	rcf_in_t     word_s1;
	logic        adv_s1;

	logic [31:0] pos_q;
	logic [33:0] offset_q;
	logic [63:0] shift_q;
	logic [31:0] left_q;
	logic [1:0]  phase_q;
	logic        decided_q;

	logic [31:0] pos_e, pos_n;
	logic [33:0] offset_e, offset_n;
	logic [63:0] shift_e, shift_n;
	logic [31:0] left_e, left_n;
	logic [1:0]  phase_e, phase_n;
	logic        decided_e, decided_n;

	logic [63:0] new_shift;
	logic [31:0] csize;
	logic [34:0] hdr_end;
	logic        hdr_fits;
	logic        at_hdr_last;
	logic [35:0] chunk_end;
	logic        too_big;
	logic [33:0] next_off;
	logic        next_fits;

	logic        res_valid;
	rcf_out_t    res;
	logic        out_valid_q;
	rcf_out_t    out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_size_q <= '0;
			chunk_id_q   <= MAGIC_AXML;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOTAL_SIZE: total_size_q <= cfg_data;
				REG_CHUNK_ID:   chunk_id_q   <= cfg_data;
				default:        total_size_q <= total_size_q;
			endcase
		end
	end

	assign adv_s1      = valid_s1 && (!out_valid_q || results.ready);
	assign bytes.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.valid && bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			word_s1 <= bytes.payload;
		end
	end

	// A first byte restarts the walk before the byte itself is evaluated.
	always_comb begin
		if (word_s1.first_byte) begin
			pos_e     = '0;
			offset_e  = FIRST_CHUNK;
			shift_e   = '0;
			left_e    = '0;
			phase_e   = PH_FILE_HDR;
			decided_e = 1'b0;
		end else begin
			pos_e     = pos_q;
			offset_e  = offset_q;
			shift_e   = shift_q;
			left_e    = left_q;
			phase_e   = phase_q;
			decided_e = decided_q;
		end
	end

	assign new_shift   = {word_s1.data_byte, shift_e[63:8]};
	assign csize       = new_shift[63:32];
	assign hdr_end     = {1'b0, offset_e} + HDR_LEN;
	assign hdr_fits    = hdr_end <= {3'b000, total_size_q};
	assign at_hdr_last = {3'b000, pos_e} == (hdr_end - 35'd1);
	assign chunk_end   = {1'b0, hdr_end} + {4'h0, csize};
	assign too_big     = chunk_end > {4'h0, total_size_q};
	assign next_off    = chunk_end[33:0] + {33'd0, csize[0]};
	assign next_fits   = ({1'b0, next_off} + HDR_LEN) <= {3'b000, total_size_q};

	always_comb begin
		pos_n     = pos_e;
		offset_n  = offset_e;
		shift_n   = shift_e;
		left_n    = left_e;
		phase_n   = phase_e;
		decided_n = decided_e;
		res_valid = 1'b0;
		res       = '{out_byte: 8'd0, status: ST_NOT_FOUND, last: 1'b1};
		if (!decided_e) begin
			pos_n   = pos_e + 32'd1;
			shift_n = new_shift;
			unique case (phase_e)
				PH_FILE_HDR: begin
					if (total_size_q < 32'd12) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_RIFF;
					end else if (pos_e == 32'd3 && new_shift[63:32] != MAGIC_RIFF) begin
						res_valid  = 1'b1;
						res.status = ST_NOT_RIFF;
					end else if (pos_e == 32'd11) begin
						if (new_shift[63:32] != MAGIC_WAVE) begin
							res_valid  = 1'b1;
							res.status = ST_NOT_RIFF;
						end else begin
							phase_n = PH_WALK;
							if (!hdr_fits) begin
								res_valid = 1'b1;
							end
						end
					end
				end
				PH_WALK: begin
					if (at_hdr_last) begin
						if (too_big) begin
							res_valid = 1'b1;
						end else if (new_shift[31:0] == chunk_id_q) begin
							if (csize == 32'd0) begin
								res_valid = 1'b1;
							end else begin
								left_n  = csize;
								phase_n = PH_PAYLOAD;
							end
						end else begin
							offset_n = next_off;
							if (!next_fits) begin
								res_valid = 1'b1;
							end
						end
					end
				end
				default: begin
					res_valid      = 1'b1;
					res.out_byte   = word_s1.data_byte;
					res.status     = ST_PAYLOAD;
					if (left_e <= 32'd1) begin
						left_n   = '0;
						res.last = 1'b1;
					end else begin
						left_n   = left_e - 32'd1;
						res.last = 1'b0;
					end
				end
			endcase
			if (res_valid && (res.status != ST_PAYLOAD || res.last)) begin
				decided_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			offset_q  <= FIRST_CHUNK;
			shift_q   <= '0;
			left_q    <= '0;
			phase_q   <= PH_FILE_HDR;
			decided_q <= 1'b0;
		end else if (adv_s1) begin
			pos_q     <= pos_n;
			offset_q  <= offset_n;
			shift_q   <= shift_n;
			left_q    <= left_n;
			phase_q   <= phase_n;
			decided_q <= decided_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= res_valid;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			out_q <= res;
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

endmodule

// File: bench/chunk_scan_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_scan_checker: result checker for the RIFF chunk finder
// Watches the byte channel, the result channel and the register port. It
// walks every accepted byte through its own copy of the chunk scan, queues
// the words that the block should return and compares each returned word
// with the oldest one in the queue.
// ----------------------------------------------------------------------------
module chunk_scan_checker
	import rcf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  rcf_in_t     in_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  rcf_out_t    out_word,
	output int          results_due,
	output int          mismatches
);

	logic [31:0] file_length;
	logic [31:0] wanted_id;

	logic [31:0] position;
	logic [33:0] next_offset;
	logic [63:0] hdr_window;
	logic [31:0] bytes_left;
	logic [1:0]  phase;
	bit          walk_done;

	rcf_out_t scan_results[$];
	int       fail_tally = 0;

	task automatic restart_scan();
		position    = '0;
		next_offset = FIRST_CHUNK;
		hdr_window  = '0;
		bytes_left  = '0;
		phase       = PH_FILE_HDR;
		walk_done   = 1'b0;
	endtask

	function automatic bit header_room();
		return (36'(next_offset) + 36'(HDR_LEN)) <= 36'(file_length);
	endfunction

	task automatic emit(input logic [7:0] b, input logic [1:0] st, input logic last);
		rcf_out_t w;
		w.out_byte = b;
		w.status   = st;
		w.last     = last;
		scan_results.push_back(w);
		if (st != ST_PAYLOAD || last)
			walk_done = 1'b1;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic first);
		logic [31:0] pos;
		logic [31:0] csize;
		logic [31:0] cid;
		logic [35:0] chunk_end;
		if (first)
			restart_scan();
		if (walk_done)
			return;
		pos        = position;
		position   = position + 32'd1;
		hdr_window = {b, hdr_window[63:8]};
		case (phase)
			PH_FILE_HDR: begin
				if (file_length < FIRST_CHUNK) begin
					emit(8'd0, ST_NOT_RIFF, 1'b1);
				end else if (pos == 32'd3 && hdr_window[63:32] != MAGIC_RIFF) begin
					emit(8'd0, ST_NOT_RIFF, 1'b1);
				end else if (pos == 32'd11) begin
					if (hdr_window[63:32] != MAGIC_WAVE) begin
						emit(8'd0, ST_NOT_RIFF, 1'b1);
					end else begin
						phase = PH_WALK;
						if (!header_room())
							emit(8'd0, ST_NOT_FOUND, 1'b1);
					end
				end
			end
			PH_WALK: begin
				// Only the last byte of a chunk header matters here.
				if (36'(pos) == 36'(next_offset) + 36'(HDR_LEN) - 36'd1) begin
					cid       = hdr_window[31:0];
					csize     = hdr_window[63:32];
					chunk_end = 36'(next_offset) + 36'(HDR_LEN) + 36'(csize);
					if (chunk_end > 36'(file_length)) begin
						emit(8'd0, ST_NOT_FOUND, 1'b1);
					end else if (cid == wanted_id) begin
						if (csize == 32'd0) begin
							emit(8'd0, ST_NOT_FOUND, 1'b1);
						end else begin
							bytes_left = csize;
							phase      = PH_PAYLOAD;
						end
					end else begin
						next_offset = 34'(chunk_end + 36'(csize[0]));
						if (!header_room())
							emit(8'd0, ST_NOT_FOUND, 1'b1);
					end
				end
			end
			default: begin
				if (bytes_left <= 32'd1) begin
					bytes_left = '0;
					emit(b, ST_PAYLOAD, 1'b1);
				end else begin
					bytes_left = bytes_left - 32'd1;
					emit(b, ST_PAYLOAD, 1'b0);
				end
			end
		endcase
	endtask

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t ns  %s: got %0h, want %0h", $time, what, got, want);
		fail_tally++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rcf_out_t want;
		if (!arst_n) begin
			file_length = '0;
			wanted_id   = MAGIC_AXML;
			restart_scan();
			scan_results.delete();
			results_due <= 0;
			mismatches  <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TOTAL_SIZE)
					file_length = cfg_data;
				else
					wanted_id = cfg_data;
			end
			// Returned words are taken first: none can stem from a byte of this edge.
			if (out_valid && out_ready) begin
				if (scan_results.size() == 0) begin
					report("result word with none due", out_word.out_byte, 8'd0);
				end else begin
					want = scan_results.pop_front();
					if (out_word.out_byte !== want.out_byte)
						report("out_byte", out_word.out_byte, want.out_byte);
					if (out_word.status !== want.status)
						report("status", 8'(out_word.status), 8'(want.status));
					if (out_word.last !== want.last)
						report("last", 8'(out_word.last), 8'(want.last));
				end
			end
			if (in_valid && in_ready)
				scan_byte(in_word.data_byte, in_word.first_byte);
			results_due <= scan_results.size();
			mismatches  <= fail_tally;
		end
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level of the RIFF chunk finder bench
// Feeds RIFF WAVE files, broken files and noise through the byte channel
// under changing file lengths and chunk IDs, with random gaps on both
// channels and one long receiver stall. A checker beside the block predicts
// and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
	import rcf_pkg::*;

	localparam int ITEM_TARGET    = 1350;
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_BODY       = 48;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	rcf_in_if  byte_ch ();
	rcf_out_if result_ch ();

	int results_due;
	int mismatches;

	int tx_idle_pct = 14;
	int rx_idle_pct = 64;
	bit hold_req    = 1'b0;
	bit hold_used   = 1'b0;
	int hold_left   = 0;
	int quiet_cycles = 0;
	int items_sent  = 0;

	logic [7:0] img[$];

	riff_chunk_finder u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.bytes    (byte_ch),
		.results  (result_ch)
	);

	chunk_scan_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (byte_ch.valid),
		.in_ready   (byte_ch.ready),
		.in_word    (byte_ch.payload),
		.out_valid  (result_ch.valid),
		.out_ready  (result_ch.ready),
		.out_word   (result_ch.payload),
		.results_due(results_due),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Receiver: random stalls, plus one long hold once a word shows up after the hold is requested.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used && result_ch.valid) begin
			result_ch.ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_ch.valid && byte_ch.ready) ||
				(result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("riff_chunk_finder: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_config(input logic [31:0] length, input logic [31:0] id,
			input bit with_id);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TOTAL_SIZE;
		cfg_data  <= length;
		@(posedge clk);
		if (with_id) begin
			cfg_index <= REG_CHUNK_ID;
			cfg_data  <= id;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < tx_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.payload <= '{data_byte: b, first_byte: first};
		do @(posedge clk); while (!byte_ch.ready);
		items_sent++;
	endtask

	// Occasionally a word in the middle of a file restarts the walk.
	task automatic send_file(input logic first);
		foreach (img[i])
			send_byte(img[i], (i == 0) ? first : ($urandom_range(199) == 0));
	endtask

	task automatic finish_phase();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void put_word(input logic [31:0] w);
		for (int k = 0; k < 4; k++)
			img.push_back(w[8*k +: 8]);
	endfunction

	function automatic logic [31:0] ascii_id();
		return {8'($urandom_range(97, 122)), 8'($urandom_range(97, 122)),
			8'($urandom_range(97, 122)), 8'($urandom_range(32, 126))};
	endfunction

	function automatic logic [31:0] pick_size();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 32'($urandom_range(0, 12));
		else if (r < 90)
			return 32'($urandom_range(13, 40));
		return $urandom;
	endfunction

	// Body bytes are capped so that huge chunks end the image early.
	function automatic void put_chunk(input logic [31:0] id, input logic [31:0] size);
		put_word(id);
		put_word(size);
		for (int k = 0; k < MAX_BODY && k < size; k++)
			img.push_back(8'($urandom));
		if (size[0] && size <= MAX_BODY)
			img.push_back(8'($urandom));
	endfunction

	function automatic void put_file_header();
		put_word(MAGIC_RIFF);
		put_word($urandom);
		put_word(MAGIC_WAVE);
	endfunction

	function automatic void build_file(input logic [31:0] want_id);
		int          n_chunks;
		int          match_at;
		bit          has_match;
		logic [31:0] size;
		logic [31:0] id;
		int          idx;
		img.delete();
		put_file_header();
		if ($urandom_range(9) == 0) begin
			idx = $urandom_range(1) ? $urandom_range(0, 3) : $urandom_range(8, 11);
			img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
		end
		n_chunks  = $urandom_range(0, 3);
		match_at  = $urandom_range(0, n_chunks);
		has_match = ($urandom_range(3) != 0);
		for (int c = 0; c <= n_chunks; c++) begin
			size = pick_size();
			if (has_match && c == match_at) begin
				id = want_id;
			end else begin
				id = ascii_id();
				if (id == want_id)
					id = id ^ 32'd1;
			end
			put_chunk(id, size);
			if (size > MAX_BODY)
				break;
		end
		if ($urandom_range(9) < 3)
			repeat ($urandom_range(0, 6)) img.push_back(8'($urandom));
	endfunction

	function automatic void build_noise();
		img.delete();
		if ($urandom_range(1))
			put_word(MAGIC_RIFF);
		repeat ($urandom_range(1, 16)) img.push_back(8'($urandom));
	endfunction

	function automatic logic [31:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return 32'($urandom_range(0, 11));
		else if (r < 20)
			return 32'($urandom_range(12, 27));
		else if (r < 25)
			return '1;
		else if (r < 30)
			return $urandom;
		return 32'($urandom_range(30, 140));
	endfunction

	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return MAGIC_AXML;
		else if (r < 7)
			return ascii_id();
		else if (r == 7)
			return '0;
		else if (r == 8)
			return '1;
		return $urandom;
	endfunction

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = REG_TOTAL_SIZE;
		cfg_data          = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.payload   = '0;
		result_ch.ready   = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero length with the reset chunk ID, and no first flag on the very
		// first word: it still counts as position zero and fails at once.
		set_config(32'd0, 32'd0, 1'b0);
		send_byte(8'h52, 1'b0);
		send_byte(8'hFF, 1'b0);
		finish_phase();

		// All-ones length and ID, two-byte match carrying both byte extremes.
		set_config('1, '1, 1'b1);
		img.delete();
		put_file_header();
		put_word('1);
		put_word(32'd2);
		img.push_back(8'h00);
		img.push_back(8'hFF);
		send_file(1'b1);
		finish_phase();

		// Long match while the receiver holds off, so the block backs up.
		set_config(32'd200, MAGIC_AXML, 1'b1);
		img.delete();
		put_file_header();
		put_word(MAGIC_AXML);
		put_word(32'd100);
		repeat (100) img.push_back(8'($urandom));
		hold_req <= 1'b1;
		send_file(1'b1);
		finish_phase();
		hold_req <= 1'b0;

		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= 2 * ITEM_TARGET / 3) begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end else if (items_sent >= ITEM_TARGET / 3) begin
				tx_idle_pct <= 64;
				rx_idle_pct <= 14;
			end
			set_config(pick_length(), pick_id(), ($urandom_range(9) != 0));
			repeat ($urandom_range(2, 4)) begin
				if ($urandom_range(4) != 0) begin
					build_file(u_checker.wanted_id);
					send_file(1'b1);
				end else begin
					build_noise();
					send_file($urandom_range(9) < 7);
				end
			end
			finish_phase();
		end

		if (mismatches == 0)
			$display("riff_chunk_finder: match");
		else
			$display("riff_chunk_finder: mismatch");
		$finish;
	end

endmodule

// File: riff_chunk_finder.f
rtl/rcf_pkg.sv
rtl/rcf_in_if.sv
rtl/rcf_out_if.sv
rtl/riff_chunk_finder.sv
bench/chunk_scan_checker.sv
bench/testbench.sv
